>>> src/rbsi_pkg.sv
`timescale 1ns / 1ps

package rbsi_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_AXES      = 3;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } t_cfg_idx;

    typedef logic signed [DATA_W-1:0] t_fix;

endpackage

>>> src/rbsi_plane.sv
`timescale 1ns / 1ps

module rbsi_plane #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  rbsi_pkg::t_fix i_bound,
    input  rbsi_pkg::t_fix i_origin,
    input  rbsi_pkg::t_fix i_recip,
    output rbsi_pkg::t_fix o_dist
);
    import rbsi_pkg::*;

    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(1) << (DATA_W - 1);
    localparam logic [PROD_W-1:0] POS_LIM = NEG_LIM - PROD_W'(1);

    logic signed [DIFF_W-1:0] n_diff;
    logic [DIFF_W-1:0]        n_mag_d, r_mag_d;
    logic [DATA_W-1:0]        n_mag_r, r_mag_r;
    logic                     n_neg1, r_neg1;
    logic [PROD_W-1:0]        n_prod;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_neg2;
    logic [PROD_W-1:0]        n_round;
    logic [PROD_W-1:0]        n_mag_q;
    t_fix                     n_dist, r_dist;

    // stage 1: exact difference and magnitudes
    always_comb begin
        n_diff  = DIFF_W'(i_bound) - DIFF_W'(i_origin);
        n_mag_d = n_diff[DIFF_W-1] ? DIFF_W'(-n_diff) : DIFF_W'(n_diff);
        n_mag_r = i_recip[DATA_W-1] ? DATA_W'(-i_recip) : DATA_W'(i_recip);
        n_neg1  = n_diff[DIFF_W-1] ^ i_recip[DATA_W-1];
    end

    // stage 2: unsigned product
    assign n_prod = PROD_W'(r_mag_d) * PROD_W'(r_mag_r);

    // stage 3: round half away from zero on the magnitude, then saturate
    always_comb begin
        n_round = r_prod + HALF;
        n_mag_q = n_round >> FRAC_BITS;
        if (r_neg2) begin
            if (n_mag_q > NEG_LIM) begin
                n_dist = t_fix'(NEG_LIM[DATA_W-1:0]);
            end else begin
                n_dist = t_fix'(-n_mag_q[DATA_W-1:0]);
            end
        end else begin
            if (n_mag_q > POS_LIM) begin
                n_dist = t_fix'(POS_LIM[DATA_W-1:0]);
            end else begin
                n_dist = t_fix'(n_mag_q[DATA_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_d <= n_mag_d;
        r_mag_r <= n_mag_r;
        r_neg1  <= n_neg1;
        r_prod  <= n_prod;
        r_neg2  <= r_neg1;
        r_dist  <= n_dist;
    end

    assign o_dist = r_dist;

endmodule

>>> src/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// Output: an accepted transfer enters r_vld[0] and moves down the r_vld valid chain;
// o_strobe is the last stage of that chain and holds for one cycle.
// Throughput: one ray per cycle; busy stays low and the receiver cannot stall.
// Reset: synchronous active low; flushes all in-flight rays and loads the box
// registers with min -1.0 and max +1.0 on every axis.
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rbsi_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  rbsi_pkg::t_fix                     i_origin_x,
    input  rbsi_pkg::t_fix                     i_origin_y,
    input  rbsi_pkg::t_fix                     i_origin_z,
    input  rbsi_pkg::t_fix                     i_recip_dir_x,
    input  rbsi_pkg::t_fix                     i_recip_dir_y,
    input  rbsi_pkg::t_fix                     i_recip_dir_z,
    output logic                               o_strobe,
    output logic                               o_hit,
    output rbsi_pkg::t_fix                     o_distance
);
    import rbsi_pkg::*;

    localparam int   STAGES   = 6;
    localparam t_fix ONE      = t_fix'(DATA_W'(1) << FRAC_BITS);
    localparam t_fix MIN_RST  = t_fix'(-ONE);

    t_fix r_box_min [NUM_AXES];
    t_fix r_box_max [NUM_AXES];
    t_fix w_org     [NUM_AXES];
    t_fix w_rec     [NUM_AXES];
    t_fix w_dmin    [NUM_AXES];
    t_fix w_dmax    [NUM_AXES];

    logic                r_vld [STAGES];
    logic                n_take;
    logic [NUM_AXES-1:0] r_rneg1, r_rneg2, r_rneg3;

    t_fix n_e [NUM_AXES];
    t_fix n_x [NUM_AXES];

    // stage 4/5 narrowing
    logic n_miss4, r_miss4, n_miss5, r_miss5;
    t_fix n_lo4, n_hi4, r_lo4, r_hi4, r_e4z, r_x4z;
    t_fix n_lo5, n_hi5, r_lo5, r_hi5;
    logic n_hit;
    t_fix n_dist;
    logic r_hit;
    t_fix r_dist;

    assign busy   = 1'b0;
    assign n_take = start && !busy;

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_rec[0] = i_recip_dir_x;
    assign w_rec[1] = i_recip_dir_y;
    assign w_rec[2] = i_recip_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_box_min[a] <= MIN_RST;
                r_box_max[a] <= ONE;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOX_MIN_X: r_box_min[0] <= t_fix'(i_cfg_data);
                CFG_BOX_MIN_Y: r_box_min[1] <= t_fix'(i_cfg_data);
                CFG_BOX_MIN_Z: r_box_min[2] <= t_fix'(i_cfg_data);
                CFG_BOX_MAX_X: r_box_max[0] <= t_fix'(i_cfg_data);
                CFG_BOX_MAX_Y: r_box_max[1] <= t_fix'(i_cfg_data);
                CFG_BOX_MAX_Z: r_box_max[2] <= t_fix'(i_cfg_data);
                default: ;
            endcase
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        rbsi_plane #(.FRAC_BITS(FRAC_BITS)) u_plane_min (
            .i_clk    (i_clk),
            .i_bound  (r_box_min[a]),
            .i_origin (w_org[a]),
            .i_recip  (w_rec[a]),
            .o_dist   (w_dmin[a])
        );
        rbsi_plane #(.FRAC_BITS(FRAC_BITS)) u_plane_max (
            .i_clk    (i_clk),
            .i_bound  (r_box_max[a]),
            .i_origin (w_org[a]),
            .i_recip  (w_rec[a]),
            .o_dist   (w_dmax[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= n_take;
            for (int s = 1; s < STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // order each pair as entry <= exit
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_e[a] = r_rneg3[a] ? w_dmax[a] : w_dmin[a];
            n_x[a] = r_rneg3[a] ? w_dmin[a] : w_dmax[a];
        end
    end

    always_comb begin
        n_miss4 = (n_e[0] > n_x[1]) || (n_e[1] > n_x[0]);
        n_lo4   = (n_e[0] < n_e[1]) ? n_e[1] : n_e[0];
        n_hi4   = (n_x[0] > n_x[1]) ? n_x[1] : n_x[0];
    end

    always_comb begin
        n_miss5 = r_miss4 || (r_lo4 > r_x4z) || (r_e4z > r_hi4);
        n_lo5   = (r_lo4 < r_e4z) ? r_e4z : r_lo4;
        n_hi5   = (r_hi4 > r_x4z) ? r_x4z : r_hi4;
    end

    // nearest non-negative distance
    always_comb begin
        n_hit  = 1'b0;
        n_dist = '0;
        if (!r_miss5) begin
            if (!r_lo5[DATA_W-1]) begin
                n_hit  = 1'b1;
                n_dist = r_lo5;
            end else if (!r_hi5[DATA_W-1]) begin
                n_hit  = 1'b1;
                n_dist = r_hi5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rneg1 <= {i_recip_dir_z[DATA_W-1], i_recip_dir_y[DATA_W-1],
                    i_recip_dir_x[DATA_W-1]};
        r_rneg2 <= r_rneg1;
        r_rneg3 <= r_rneg2;
        r_miss4 <= n_miss4;
        r_lo4   <= n_lo4;
        r_hi4   <= n_hi4;
        r_e4z   <= n_e[2];
        r_x4z   <= n_x[2];
        r_miss5 <= n_miss5;
        r_lo5   <= n_lo5;
        r_hi5   <= n_hi5;
        r_hit   <= n_hit;
        r_dist  <= n_dist;
    end

    assign o_strobe   = r_vld[STAGES-1];
    assign o_hit      = r_hit;
    assign o_distance = r_dist;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_take |-> ##6 o_strobe)
        else $error("accepted transfer did not produce a result on time");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_hit |-> o_distance == '0)
        else $error("miss with nonzero distance");

    a_hit_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_hit |-> !o_distance[DATA_W-1])
        else $error("hit with negative distance");

    a_cfg_min_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == CFG_BOX_MIN_X |=>
            r_box_min[0] == t_fix'($past(i_cfg_data)))
        else $error("box min x write lost");
`endif

endmodule
